@@ src/wce_pkg.sv @@
`timescale 1ns / 1ps

package wce_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int DIGIT_W         = 4;
    localparam int CSUM_W          = 10;
    localparam int QUEUE_DEPTH     = 4;

    localparam int DEF_MSG_BYTES   = 32;
    localparam int DEF_LOG_W       = 4;
    localparam int DEF_CSUM_DIGITS = 3;

    // One accepted byte as handed from the front to the back.
    typedef struct packed {
        logic [BYTE_BITS-1:0] msg_byte;
        logic                 is_final;
        logic [CSUM_W-1:0]    csum;
    } wce_job_t;

endpackage

@@ src/wce_front.sv @@
`timescale 1ns / 1ps

module wce_front
    import wce_pkg::*;
#(
    parameter int MSG_BYTES = DEF_MSG_BYTES,
    parameter int LOG_W     = DEF_LOG_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_BITS-1:0] msg_byte,
    input  logic                 q_full,
    output logic                 push,
    output wce_job_t             push_job
);

    localparam int DPB = BYTE_BITS / LOG_W;
    localparam int PW  = $clog2(MSG_BYTES + 1);
    localparam logic [BYTE_BITS-1:0] DMASK = BYTE_BITS'((9'd1 << LOG_W) - 9'd1);

    logic [PW-1:0]     byte_position_reg;
    logic [PW-1:0]     byte_position_next;
    logic [CSUM_W-1:0] checksum_sum_reg;
    logic [CSUM_W-1:0] checksum_sum_next;
    logic [CSUM_W-1:0] csum_acc;
    logic              accept;
    logic              final_byte;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign push       = accept;
    assign final_byte = (byte_position_reg == PW'(MSG_BYTES - 1));

    // Each message digit adds its complement to w-1 into the running sum.
    always_comb
    begin
        logic [BYTE_BITS-1:0] d;
        csum_acc = checksum_sum_reg;
        for (int i = 0; i < DPB; i++)
        begin
            d        = BYTE_BITS'(msg_byte >> (BYTE_BITS - (i + 1) * LOG_W)) & DMASK;
            csum_acc = csum_acc + CSUM_W'(DMASK - d);
        end
    end

    always_comb
    begin
        push_job.msg_byte = msg_byte;
        push_job.is_final = final_byte;
        push_job.csum     = csum_acc;
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        checksum_sum_next  = checksum_sum_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                byte_position_next = '0;
                checksum_sum_next  = '0;
            end
            else
            begin
                byte_position_next = byte_position_reg + PW'(1);
                checksum_sum_next  = csum_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            checksum_sum_reg  <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            checksum_sum_reg  <= checksum_sum_next;
        end
    end

endmodule

@@ src/wce_queue.sv @@
`timescale 1ns / 1ps

module wce_queue
    import wce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  wce_job_t push_job,
    output logic     q_full,
    input  logic     pop,
    output wce_job_t head,
    output logic     q_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    wce_job_t      mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign q_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/wce_back.sv @@
`timescale 1ns / 1ps

module wce_back
    import wce_pkg::*;
#(
    parameter int LOG_W       = DEF_LOG_W,
    parameter int CSUM_DIGITS = DEF_CSUM_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  wce_job_t           head,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIGIT_W-1:0] digit,
    output logic               is_checksum,
    output logic               last
);

    localparam int DPB  = BYTE_BITS / LOG_W;
    localparam int CSW  = CSUM_DIGITS * LOG_W;
    localparam int ML_W = $clog2(DPB + 1);
    localparam int CL_W = $clog2(CSUM_DIGITS + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic [BYTE_BITS-1:0] byte_sr_reg;
    logic [BYTE_BITS-1:0] byte_sr_next;
    logic [CSW-1:0]       csum_sr_reg;
    logic [CSW-1:0]       csum_sr_next;
    logic [ML_W-1:0]      msg_left_reg;
    logic [ML_W-1:0]      msg_left_next;
    logic [CL_W-1:0]      csum_left_reg;
    logic [CL_W-1:0]      csum_left_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [DIGIT_W-1:0]   digit_next;
    logic                 is_checksum_reg;
    logic                 is_checksum_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 out_free;
    logic                 emit;
    logic [BYTE_BITS-1:0] top8;
    logic [CSW-1:0]       head_csum;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = out_free && (busy_reg || !q_empty);
    assign pop       = out_free && !busy_reg && !q_empty;
    assign head_csum = CSW'(head.csum);

    // A fresh job from the queue loads its first digit into the output register
    // in the same cycle that it is popped.
    always_comb
    begin
        busy_next        = busy_reg;
        byte_sr_next     = byte_sr_reg;
        csum_sr_next     = csum_sr_reg;
        msg_left_next    = msg_left_reg;
        csum_left_next   = csum_left_reg;
        out_valid_next   = out_valid_reg && out_stall;
        digit_next       = digit_reg;
        is_checksum_next = is_checksum_reg;
        last_next        = last_reg;
        top8             = '0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (!busy_reg)
            begin
                top8             = BYTE_BITS'(head.msg_byte >> (BYTE_BITS - LOG_W));
                digit_next       = top8[DIGIT_W-1:0];
                is_checksum_next = 1'b0;
                last_next        = 1'b0;
                byte_sr_next     = BYTE_BITS'(head.msg_byte << LOG_W);
                csum_sr_next     = head_csum;
                msg_left_next    = ML_W'(DPB - 1);
                csum_left_next   = head.is_final ? CL_W'(CSUM_DIGITS) : '0;
                busy_next        = (DPB > 1) || head.is_final;
            end
            else if (msg_left_reg != '0)
            begin
                top8             = BYTE_BITS'(byte_sr_reg >> (BYTE_BITS - LOG_W));
                digit_next       = top8[DIGIT_W-1:0];
                is_checksum_next = 1'b0;
                last_next        = 1'b0;
                byte_sr_next     = BYTE_BITS'(byte_sr_reg << LOG_W);
                msg_left_next    = msg_left_reg - ML_W'(1);
                busy_next        = (msg_left_reg != ML_W'(1)) || (csum_left_reg != '0);
            end
            else
            begin
                top8             = BYTE_BITS'(csum_sr_reg >> (CSW - LOG_W));
                digit_next       = top8[DIGIT_W-1:0];
                is_checksum_next = 1'b1;
                last_next        = (csum_left_reg == CL_W'(1));
                csum_sr_next     = CSW'(csum_sr_reg << LOG_W);
                csum_left_next   = csum_left_reg - CL_W'(1);
                busy_next        = (csum_left_reg != CL_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_sr_reg     <= byte_sr_next;
        csum_sr_reg     <= csum_sr_next;
        digit_reg       <= digit_next;
        is_checksum_reg <= is_checksum_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            msg_left_reg  <= '0;
            csum_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            msg_left_reg  <= msg_left_next;
            csum_left_reg <= csum_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit       = digit_reg;
    assign is_checksum = is_checksum_reg;
    assign last        = last_reg;

endmodule

@@ src/wots_chain_length_encoder_core.sv @@
`timescale 1ns / 1ps
// WOTS+ chain length encoder (base-w digits with checksum).
// Input channel: one message byte per transaction on msg_byte, with
// in_valid and in_stall. Output channel: one digit per transaction on
// digit, is_checksum and last, with out_valid and out_stall.
// Each byte yields 8/LOG_W message digits, most significant first. After
// byte MSG_BYTES-1 the block also emits CSUM_DIGITS checksum digits, the
// final one marked by last, and the byte count and checksum clear.
// When the block is otherwise empty, an accepted byte passes through the queue
// and then the output register before its first digit appears.
// Throughput: one digit per cycle from the output register while out_stall is
// low and bytes are waiting; the digit expander in the back end sets this rate.
// A four-entry queue between the byte front end and the expander lets input
// be accepted while output is stalled; in_stall rises only when it is full.
// A stalled output holds its digit until taken. Reset clears the byte
// count, the checksum, the queue and the output valid.

module wots_chain_length_encoder_core
    import wce_pkg::*;
#(
    parameter int MSG_BYTES   = DEF_MSG_BYTES,
    parameter int LOG_W       = DEF_LOG_W,
    parameter int CSUM_DIGITS = DEF_CSUM_DIGITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_BITS-1:0] msg_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DIGIT_W-1:0]   digit,
    output logic                 is_checksum,
    output logic                 last
);

    wce_job_t push_job;
    wce_job_t head;
    logic     push;
    logic     q_full;
    logic     pop;
    logic     q_empty;

    wce_front #(
        .MSG_BYTES (MSG_BYTES),
        .LOG_W     (LOG_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .msg_byte (msg_byte),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    wce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full),
        .pop      (pop),
        .head     (head),
        .q_empty  (q_empty)
    );

    wce_back #(
        .LOG_W       (LOG_W),
        .CSUM_DIGITS (CSUM_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit       (digit),
        .is_checksum (is_checksum),
        .last        (last)
    );

endmodule

@@ src/wce_checker.sv @@
`timescale 1ns / 1ps

module wce_checker
    import wce_pkg::*;
#(
    parameter int LOG_W = DEF_LOG_W
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [BYTE_BITS-1:0] msg_byte,
    input logic               out_valid,
    input logic               out_stall,
    input logic [DIGIT_W-1:0] digit,
    input logic               is_checksum,
    input logic               last
);

    localparam int DMAX = (LOG_W >= DIGIT_W) ? ((1 << DIGIT_W) - 1) : ((1 << LOG_W) - 1);

    logic in_csum_reg;
    logic out_take;

    assign out_take = out_valid && !out_stall;

    // Tracks whether the checksum run of a message has started but not ended.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_csum_reg <= 1'b0;
        end
        else if (out_take && is_checksum)
        begin
            in_csum_reg <= !last;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(msg_byte))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit) && $stable(is_checksum)
            && $stable(last))
        else $error("output transaction changed while stalled");

    a_last_is_csum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> is_checksum)
        else $error("last flag on a message digit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(digit) <= DMAX)
        else $error("digit exceeds w-1");

    a_csum_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_csum_reg |-> is_checksum)
        else $error("message digit inside a checksum run");

endmodule

bind wots_chain_length_encoder_core wce_checker #(.LOG_W(LOG_W)) u_wce_checker (.*);

@@ tb/wots_chain_length_encoder_core_test.sv @@
`timescale 1ns / 1ps

module wots_chain_length_encoder_core_test;
    import wce_pkg::*;

    localparam int MSG_BYTES   = DEF_MSG_BYTES;
    localparam int LOG_W       = DEF_LOG_W;
    localparam int CSUM_DIGITS = DEF_CSUM_DIGITS;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_MESSAGES = 6;
    localparam logic [31:0] DIGIT_MASK = (32'd1 << LOG_W) - 32'd1;

    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic               is_checksum;
        logic               last;
    } chain_digit_t;

    typedef enum int {
        MSG_RANDOM,
        MSG_ALL_ZERO,
        MSG_ALL_ONES,
        MSG_NIBBLE_EDGE
    } msg_kind_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_BITS-1:0] msg_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DIGIT_W-1:0] digit;
    logic               is_checksum;
    logic               last;

    chain_digit_t       digit_expect_q[$];
    int unsigned        msg_pos = 0;
    logic [CSUM_W-1:0]  csum_acc = '0;
    int unsigned        error_count = 0;
    int unsigned        burst_left = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        cycle_count = 0;
    int unsigned        stall_run = 0;

    wots_chain_length_encoder_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .msg_byte    (msg_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit       (digit),
        .is_checksum (is_checksum),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Splits one accepted byte into digits and, on the final byte of a message,
    // appends the checksum digits taken from the low bits of the running sum.
    task automatic encode_byte(input logic [BYTE_BITS-1:0] b);
        int bits;
        int unsigned sh;
        logic [31:0] d;
        chain_digit_t item;
        bits = BYTE_BITS;
        while (bits >= LOG_W)
        begin
            bits -= LOG_W;
            d = (32'(b) >> bits) & DIGIT_MASK;
            csum_acc = csum_acc + CSUM_W'(DIGIT_MASK - d);
            item.digit = d[DIGIT_W-1:0];
            item.is_checksum = 1'b0;
            item.last = 1'b0;
            digit_expect_q.push_back(item);
        end
        if (msg_pos >= MSG_BYTES - 1)
        begin
            for (int k = 0; k < CSUM_DIGITS; k++)
            begin
                sh = (CSUM_DIGITS - 1 - k) * LOG_W;
                d = (sh < 32) ? ((32'(csum_acc) >> sh) & DIGIT_MASK) : 32'd0;
                item.digit = d[DIGIT_W-1:0];
                item.is_checksum = 1'b1;
                item.last = (k == CSUM_DIGITS - 1);
                digit_expect_q.push_back(item);
            end
            msg_pos = 0;
            csum_acc = '0;
        end
        else
        begin
            msg_pos++;
        end
    endtask

    // Valid is lowered only when a real gap follows, so a burst keeps it high.
    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        msg_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        encode_byte(b);
    endtask

    task automatic test_digit_split();
        logic [BYTE_BITS-1:0] patterns[16] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h10,
                                              8'h80, 8'h08, 8'h7F, 8'hF7, 8'h55, 8'hAA,
                                              8'h12, 8'h34, 8'hC3, 8'h3C};
        foreach (patterns[i])
            send_byte(patterns[i]);
    endtask

    function automatic logic [BYTE_BITS-1:0] make_byte(input msg_kind_t kind);
        logic [BYTE_BITS-1:0] b;
        b = BYTE_BITS'($urandom_range(0, 255));
        case (kind)
            MSG_ALL_ZERO: b = '0;
            MSG_ALL_ONES: b = '1;
            MSG_NIBBLE_EDGE:
            begin
                // Each nibble is forced to a digit extreme most of the time.
                case ($urandom_range(0, 2))
                    0: b[7:4] = 4'h0;
                    1: b[7:4] = 4'hF;
                    default: ;
                endcase
                case ($urandom_range(0, 2))
                    0: b[3:0] = 4'h0;
                    1: b[3:0] = 4'hF;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return b;
    endfunction

    // The all-zero and all-ones messages hit the largest and smallest checksum.
    task automatic test_random_messages();
        msg_kind_t kind;
        while (msg_pos != 0)
            send_byte(make_byte(MSG_RANDOM));
        for (int m = 0; m < RANDOM_MESSAGES; m++)
        begin
            if (m < 4)
                kind = msg_kind_t'(m);
            else
                kind = msg_kind_t'($urandom_range(0, 3));
            for (int i = 0; i < MSG_BYTES; i++)
                send_byte(make_byte(kind));
        end
    endtask

    // Receiver stall pattern rotates through free-running, light, heavy and bursty.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 150) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run <= stall_run - 1;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_run <= $urandom_range(1, 8);
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        chain_digit_t exp_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digit_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit %0h chk %0b last %0b",
                                          digit, is_checksum, last));
            end
            else
            begin
                exp_item = digit_expect_q.pop_front();
                if (digit !== exp_item.digit)
                    report_mismatch($sformatf("digit %0h, expected %0h",
                                              digit, exp_item.digit));
                if (is_checksum !== exp_item.is_checksum)
                    report_mismatch($sformatf("is_checksum %0b, expected %0b",
                                              is_checksum, exp_item.is_checksum));
                if (last !== exp_item.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              last, exp_item.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_digit_split();
        test_random_messages();
        in_valid <= 1'b0;
        while (digit_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ wots_chain_length_encoder_core.f @@
src/wce_pkg.sv
src/wce_front.sv
src/wce_queue.sv
src/wce_back.sv
src/wots_chain_length_encoder_core.sv
src/wce_checker.sv
tb/wots_chain_length_encoder_core_test.sv
